// ===== rtl/core/vpv_pkg.sv =====
// Shared widths, codes, stage payload types and pan curves for the voice volume calculator.
package vpv_pkg;

    localparam int SONG_TRACKS = 13;
    localparam int NUM_TRACKS  = 32;

    localparam int TRACK_W = 5;
    localparam int VOL_W   = 8;
    localparam int PAN_W   = 10;
    localparam int SCALE_W = 16;
    localparam int SE_W    = 8;
    localparam int OUT_W   = 16;
    localparam int CURVE_W = 8;

    localparam int PAN41_MAX = 40;
    localparam int PAN41_MID = 20;
    localparam int PAN65_MAX = 64;
    localparam int PAN65_MID = 32;
    localparam int PAN41_IW  = $clog2(PAN41_MAX + 1);
    localparam int PAN65_IW  = $clog2(PAN65_MAX + 1);

    localparam int PROD_W = VOL_W + CURVE_W;
    localparam int WIDE_W = OUT_W + SCALE_W;

    // APB register map: one 32-bit register per word
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 32;
    localparam int CFG_IW  = CFG_AW - 2;
    localparam logic [CFG_IW-1:0] REG_MONO = '0;

    typedef logic [TRACK_W-1:0]  t_track;
    typedef logic [TRACK_W:0]    t_track_ext;
    typedef logic [VOL_W-1:0]    t_vol;
    typedef logic [SCALE_W-1:0]  t_scale_val;
    typedef logic [CURVE_W-1:0]  t_curve;
    typedef logic [PAN41_IW-1:0] t_pan41;
    typedef logic [PAN65_IW-1:0] t_pan65;
    typedef logic [PROD_W-1:0]   t_prod;
    typedef logic [OUT_W-1:0]    t_out_vol;

    typedef enum logic [1:0] {
        PATH_ZERO,
        PATH_SONG,
        PATH_SE_FLAT,
        PATH_SE_SCALED
    } t_path;

    // Input beat as taken from the channel
    typedef struct packed {
        t_track              track;
        t_vol                volume;
        t_vol                decay_volume;
        logic [PAN_W-1:0]    pan_position;
        t_scale_val          master_volume;
        logic [SE_W-1:0]     se_type;
        logic [SE_W-1:0]     se_pan;
        t_scale_val          se_volume;
    } t_item;

    // After decay, pan resolve and curve lookup
    typedef struct packed {
        t_track     voice;
        t_path      path;
        t_vol       vol;
        t_scale_val master;
        t_scale_val se_vol;
        t_curve     cr;
        t_curve     cl;
    } t_front;

    // After the first multiply
    typedef struct packed {
        t_track     voice;
        t_path      path;
        t_scale_val master;
        t_prod      prod_r;
        t_prod      prod_l;
        t_vol       vol2;
        t_curve     cr;
        t_curve     cl;
    } t_scale;

    // Final result
    typedef struct packed {
        t_track   voice;
        t_out_vol left_volume;
        t_out_vol right_volume;
    } t_mix;

    localparam t_curve CURVE41 [PAN41_MAX+1] = '{
        8'd0,   8'd2,   8'd4,   8'd7,   8'd10,  8'd13,  8'd16,  8'd20,  8'd24,  8'd28,
        8'd32,  8'd36,  8'd40,  8'd45,  8'd50,  8'd55,  8'd60,  8'd65,  8'd70,  8'd75,
        8'd80,  8'd84,  8'd88,  8'd92,  8'd96,  8'd100, 8'd104, 8'd107, 8'd110, 8'd112,
        8'd114, 8'd116, 8'd118, 8'd120, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127,
        8'd127
    };

    localparam t_curve CURVE65 [PAN65_MAX+1] = '{
        8'd0,   8'd2,   8'd4,   8'd6,   8'd8,   8'd10,  8'd14,  8'd18,  8'd22,  8'd28,
        8'd34,  8'd40,  8'd46,  8'd52,  8'd58,  8'd64,  8'd70,  8'd76,  8'd82,  8'd88,
        8'd94,  8'd100, 8'd106, 8'd112, 8'd118, 8'd124, 8'd130, 8'd136, 8'd142, 8'd148,
        8'd154, 8'd160, 8'd166, 8'd172, 8'd178, 8'd183, 8'd188, 8'd193, 8'd198, 8'd203,
        8'd208, 8'd213, 8'd217, 8'd221, 8'd224, 8'd227, 8'd230, 8'd233, 8'd236, 8'd238,
        8'd240, 8'd242, 8'd244, 8'd246, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253,
        8'd254, 8'd254, 8'd255, 8'd255, 8'd255
    };

endpackage

// ===== rtl/core/vpv_in_if.sv =====
// Input channel: voice update beats with valid/ready handshake.
interface vpv_in_if;
    logic                       valid;
    logic                       ready;
    logic [vpv_pkg::TRACK_W-1:0] track;
    logic [vpv_pkg::VOL_W-1:0]   volume;
    logic [vpv_pkg::VOL_W-1:0]   decay_volume;
    logic [vpv_pkg::PAN_W-1:0]   pan_position;
    logic [vpv_pkg::SCALE_W-1:0] master_volume;
    logic [vpv_pkg::SE_W-1:0]    se_type;
    logic [vpv_pkg::SE_W-1:0]    se_pan;
    logic [vpv_pkg::SCALE_W-1:0] se_volume;

    modport source (
        output valid, track, volume, decay_volume, pan_position,
               master_volume, se_type, se_pan, se_volume,
        input  ready
    );
    modport sink (
        input  valid, track, volume, decay_volume, pan_position,
               master_volume, se_type, se_pan, se_volume,
        output ready
    );
endinterface

// ===== rtl/core/vpv_out_if.sv =====
// Output channel: left/right voice volume beats with valid/ready handshake.
interface vpv_out_if;
    logic                        valid;
    logic                        ready;
    logic [vpv_pkg::TRACK_W-1:0] voice;
    logic [vpv_pkg::OUT_W-1:0]   left_volume;
    logic [vpv_pkg::OUT_W-1:0]   right_volume;

    modport source (
        output valid, voice, left_volume, right_volume,
        input  ready
    );
    modport sink (
        input  valid, voice, left_volume, right_volume,
        output ready
    );
endinterface

// ===== rtl/core/vpv_cfg.sv =====
// APB register block holding the mono output control.
module vpv_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vpv_pkg::CFG_AW-1:0]  paddr,
    input  logic [vpv_pkg::CFG_DW-1:0]  pwdata,
    output logic [vpv_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output logic                        o_mono
);
    import vpv_pkg::*;

    logic r_mono;
    logic wr_mono;

    assign pready  = 1'b1;
    assign wr_mono = psel && penable && pwrite && pready
                     && (paddr[CFG_AW-1:2] == REG_MONO);

    // Capture the mono bit on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mono <= 1'b0;
        end else if (wr_mono) begin
            r_mono <= pwdata[0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (paddr[CFG_AW-1:2] == REG_MONO) begin
            prdata = {{(CFG_DW-1){1'b0}}, r_mono};
        end
    end

    assign o_mono = r_mono;
endmodule

// ===== rtl/core/vpv_front.sv =====
// Stage 1: decay subtract, path decode, pan clamp and pan curve lookup.
module vpv_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_mono,
    input  logic            i_valid,
    input  vpv_pkg::t_item  i_data,
    output logic            o_ready,
    output logic            o_valid,
    output vpv_pkg::t_front o_data,
    input  logic            i_ready
);
    import vpv_pkg::*;

    logic   r_valid;
    t_front r_data;
    t_front n_data;
    t_vol   vol;
    t_pan41 pan41;
    t_pan65 pan65;
    t_path  path;

    assign o_ready = !r_valid || i_ready;

    // Floor the decayed volume at zero
    assign vol = (i_data.volume >= i_data.decay_volume)
                 ? t_vol'(i_data.volume - i_data.decay_volume) : '0;

    // Resolve both pan indices
    always_comb begin
        if (i_mono) begin
            pan41 = t_pan41'(PAN41_MID);
        end else if (i_data.pan_position > PAN_W'(PAN41_MAX)) begin
            pan41 = t_pan41'(PAN41_MAX);
        end else begin
            pan41 = i_data.pan_position[PAN41_IW-1:0];
        end
        if (i_mono) begin
            pan65 = t_pan65'(PAN65_MID);
        end else if (i_data.se_pan > SE_W'(PAN65_MAX)) begin
            pan65 = t_pan65'(PAN65_MAX);
        end else begin
            pan65 = i_data.se_pan[PAN65_IW-1:0];
        end
    end

    // Pick the track's path
    always_comb begin
        if (t_track_ext'({1'b0, i_data.track}) >= t_track_ext'(NUM_TRACKS)) begin
            path = PATH_ZERO;
        end else if (i_data.track < t_track'(SONG_TRACKS)) begin
            path = PATH_SONG;
        end else if (i_data.se_type == '0) begin
            path = PATH_SE_FLAT;
        end else begin
            path = PATH_SE_SCALED;
        end
    end

    // Assemble stage payload with the curve gains
    always_comb begin
        n_data.voice  = i_data.track;
        n_data.path   = path;
        n_data.vol    = vol;
        n_data.master = i_data.master_volume;
        n_data.se_vol = i_data.se_volume;
        if (path == PATH_SE_SCALED) begin
            n_data.cr = CURVE65[pan65];
            n_data.cl = CURVE65[t_pan65'(PAN65_MAX) - pan65];
        end else begin
            n_data.cr = CURVE41[pan41];
            n_data.cl = CURVE41[t_pan41'(PAN41_MAX) - pan41];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== rtl/core/vpv_scale.sv =====
// Stage 2: volume times curve gain, or volume times effect volume.
module vpv_scale (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  vpv_pkg::t_front i_data,
    output logic            o_ready,
    output logic            o_valid,
    output vpv_pkg::t_scale o_data,
    input  logic            i_ready
);
    import vpv_pkg::*;

    logic                       r_valid;
    t_scale                     r_data;
    t_scale                     n_data;
    logic [VOL_W+SCALE_W-1:0]   se_prod;

    assign o_ready = !r_valid || i_ready;
    assign se_prod = i_data.vol * i_data.se_vol;

    // First multiply per path
    always_comb begin
        n_data.voice  = i_data.voice;
        n_data.path   = i_data.path;
        n_data.master = i_data.master;
        n_data.cr     = i_data.cr;
        n_data.cl     = i_data.cl;
        n_data.prod_r = i_data.vol * i_data.cr;
        n_data.prod_l = i_data.vol * i_data.cl;
        n_data.vol2   = se_prod[VOL_W+SCALE_W-1:SCALE_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== rtl/core/vpv_mix.sv =====
// Stage 3: master volume scaling, effect curve gain or pass-through of the first product, then output register.
module vpv_mix (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  vpv_pkg::t_scale i_data,
    output logic            o_ready,
    output logic            o_valid,
    output vpv_pkg::t_mix   o_data,
    input  logic            i_ready
);
    import vpv_pkg::*;

    logic              r_valid;
    t_mix              r_data;
    t_mix              n_data;
    logic [WIDE_W-1:0] song_r;
    logic [WIDE_W-1:0] song_l;
    t_out_vol          se_r;
    t_out_vol          se_l;

    assign o_ready = !r_valid || i_ready;

    assign song_r = i_data.prod_r * i_data.master;
    assign song_l = i_data.prod_l * i_data.master;
    assign se_r   = i_data.vol2 * i_data.cr;
    assign se_l   = i_data.vol2 * i_data.cl;

    // Select the final volumes per path
    always_comb begin
        n_data.voice = i_data.voice;
        case (i_data.path)
            PATH_SONG: begin
                n_data.right_volume = song_r[WIDE_W-1:SCALE_W];
                n_data.left_volume  = song_l[WIDE_W-1:SCALE_W];
            end
            PATH_SE_FLAT: begin
                n_data.right_volume = t_out_vol'(i_data.prod_r);
                n_data.left_volume  = t_out_vol'(i_data.prod_l);
            end
            PATH_SE_SCALED: begin
                n_data.right_volume = se_r;
                n_data.left_volume  = se_l;
            end
            default: begin
                n_data.right_volume = '0;
                n_data.left_volume  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== rtl/core/voice_pan_volume_calc.sv =====
// Voice pan/volume calculator: three-stage pipeline taking one voice update beat per clock
// while o_out is not stalled, so throughput is one voice per clock. A beat accepted on i_in
// yields exactly one beat on o_out after passing the three register stages in order:
// decay/pan-curve lookup, the first multiply (volume times curve gain or effect volume),
// and the second multiply (master scaling or effect curve gain). Backpressure on o_out
// freezes the stages holding beats while empty stages keep filling, so i_in.ready is high
// whenever o_out holds no beat.
// Write mono_output (APB address 0, bit 0) only while no beats are in flight.
module voice_pan_volume_calc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    vpv_in_if.sink                      i_in,
    vpv_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vpv_pkg::CFG_AW-1:0]  paddr,
    input  logic [vpv_pkg::CFG_DW-1:0]  pwdata,
    output logic [vpv_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);
    import vpv_pkg::*;

    logic   mono;
    t_item  item;
    logic   s1_valid;
    logic   s1_ready;
    t_front s1_data;
    logic   s2_valid;
    logic   s2_ready;
    t_scale s2_data;
    t_mix   s3_data;

    // Pack the input beat
    assign item.track         = i_in.track;
    assign item.volume        = i_in.volume;
    assign item.decay_volume  = i_in.decay_volume;
    assign item.pan_position  = i_in.pan_position;
    assign item.master_volume = i_in.master_volume;
    assign item.se_type       = i_in.se_type;
    assign item.se_pan        = i_in.se_pan;
    assign item.se_volume     = i_in.se_volume;

    vpv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mono  (mono)
    );

    vpv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mono  (mono),
        .i_valid (i_in.valid),
        .i_data  (item),
        .o_ready (i_in.ready),
        .o_valid (s1_valid),
        .o_data  (s1_data),
        .i_ready (s1_ready)
    );

    vpv_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_ready (s1_ready),
        .o_valid (s2_valid),
        .o_data  (s2_data),
        .i_ready (s2_ready)
    );

    vpv_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .o_ready (s2_ready),
        .o_valid (o_out.valid),
        .o_data  (s3_data),
        .i_ready (o_out.ready)
    );

    // Unpack the result beat
    assign o_out.voice        = s3_data.voice;
    assign o_out.left_volume  = s3_data.left_volume;
    assign o_out.right_volume = s3_data.right_volume;
endmodule

// ===== rtl/core/vpv_chk.sv =====
// Port-level checker for the voice pan/volume calculator, bound to the top level.
module vpv_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [vpv_pkg::TRACK_W-1:0] i_out_voice,
    input logic [vpv_pkg::OUT_W-1:0]   i_out_left,
    input logic [vpv_pkg::OUT_W-1:0]   i_out_right
);
    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output beat present right after reset");

    // Empty output stage means every stage can take a beat
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output stage is empty");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_voice) && $stable(i_out_left) && $stable(i_out_right))
        else $error("stalled result payload changed");
endmodule

bind voice_pan_volume_calc vpv_chk u_vpv_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_voice (o_out.voice),
    .i_out_left  (o_out.left_volume),
    .i_out_right (o_out.right_volume)
);

// ===== sim/voice_pan_volume_calc_tb.sv =====
// Self-checking testbench for the voice pan/volume calculator: directed and random beats.
module voice_pan_volume_calc_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vpv_pkg::*;

    localparam int STALL_LIMIT       = 1000;
    localparam int LONG_STALL_AT     = 150;
    localparam int LONG_STALL_CYCLES = 80;
    localparam int PIPE_SETTLE       = 8;

    // Register indexes: the mono switch, and one slot past the register list
    localparam logic [CFG_IW-1:0] REG_SPARE = 1'b1;

    // Pan gain curves, 41 and 65 steps
    localparam bit [7:0] GAIN41 [0:40] = '{
        8'd0,   8'd2,   8'd4,   8'd7,   8'd10,  8'd13,  8'd16,  8'd20,  8'd24,  8'd28,
        8'd32,  8'd36,  8'd40,  8'd45,  8'd50,  8'd55,  8'd60,  8'd65,  8'd70,  8'd75,
        8'd80,  8'd84,  8'd88,  8'd92,  8'd96,  8'd100, 8'd104, 8'd107, 8'd110, 8'd112,
        8'd114, 8'd116, 8'd118, 8'd120, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127,
        8'd127
    };
    localparam bit [7:0] GAIN65 [0:64] = '{
        8'd0,   8'd2,   8'd4,   8'd6,   8'd8,   8'd10,  8'd14,  8'd18,  8'd22,  8'd28,
        8'd34,  8'd40,  8'd46,  8'd52,  8'd58,  8'd64,  8'd70,  8'd76,  8'd82,  8'd88,
        8'd94,  8'd100, 8'd106, 8'd112, 8'd118, 8'd124, 8'd130, 8'd136, 8'd142, 8'd148,
        8'd154, 8'd160, 8'd166, 8'd172, 8'd178, 8'd183, 8'd188, 8'd193, 8'd198, 8'd203,
        8'd208, 8'd213, 8'd217, 8'd221, 8'd224, 8'd227, 8'd230, 8'd233, 8'd236, 8'd238,
        8'd240, 8'd242, 8'd244, 8'd246, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253,
        8'd254, 8'd254, 8'd255, 8'd255, 8'd255
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CFG_AW-1:0]  paddr;
    logic [CFG_DW-1:0]  pwdata;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;

    vpv_in_if  in_if ();
    vpv_out_if out_if ();

    voice_pan_volume_calc dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_item voice_feed [$];
    t_mix  mix_expected [$];
    bit    mono_q = 1'b0;
    bit    idle_on = 1'b0;
    bit    long_stall_done = 1'b0;
    logic  in_fire = 1'b0;
    int    send_gap = 0;
    int    stall_left = 0;
    int    n_voices_in = 0;
    int    n_voices_queued = 0;
    int    n_errors = 0;

    // Compute left/right voice volumes for one update under the given mono setting
    function automatic t_mix calc_voice_mix(t_item v, bit mono);
        longint unsigned lvl;
        longint unsigned pan;
        longint unsigned r;
        longint unsigned l;
        t_mix            m;
        lvl = (v.volume >= v.decay_volume) ? 64'(v.volume - v.decay_volume) : 64'd0;
        r = 0;
        l = 0;
        if (v.track >= NUM_TRACKS) begin
            r = 0;
            l = 0;
        end else if (v.track < SONG_TRACKS || v.se_type == 0) begin
            pan = (v.pan_position > PAN_W'(PAN41_MAX)) ? 64'(PAN41_MAX)
                                                        : 64'(v.pan_position);
            if (mono) pan = 64'(PAN41_MID);
            r = lvl * 64'(GAIN41[pan]);
            l = lvl * 64'(GAIN41[64'(PAN41_MAX) - pan]);
            // Song tracks also take the master volume
            if (v.track < SONG_TRACKS) begin
                r = (r * 64'(v.master_volume)) >> 16;
                l = (l * 64'(v.master_volume)) >> 16;
            end
        end else begin
            pan = (v.se_pan > SE_W'(PAN65_MAX)) ? 64'(PAN65_MAX) : 64'(v.se_pan);
            lvl = (lvl * 64'(v.se_volume)) >> 16;
            if (mono) pan = 64'(PAN65_MID);
            r = lvl * 64'(GAIN65[pan]);
            l = lvl * 64'(GAIN65[64'(PAN65_MAX) - pan]);
        end
        m.voice        = v.track;
        m.left_volume  = l[15:0];
        m.right_volume = r[15:0];
        return m;
    endfunction

    function automatic t_item mk_voice(t_track trk, t_vol vol, t_vol decay,
                                       logic [PAN_W-1:0] pan, t_scale_val master,
                                       logic [SE_W-1:0] se_type, logic [SE_W-1:0] se_pan,
                                       t_scale_val se_vol);
        t_item v;
        v.track         = trk;
        v.volume        = vol;
        v.decay_volume  = decay;
        v.pan_position  = pan;
        v.master_volume = master;
        v.se_type       = se_type;
        v.se_pan        = se_pan;
        v.se_volume     = se_vol;
        return v;
    endfunction

    // Draw a voice update; pans mostly within or just past the curve range, sometimes full range
    function automatic t_item rand_voice();
        t_item v;
        v.track         = t_track'($urandom_range(0, 31));
        v.volume        = t_vol'($urandom);
        v.decay_volume  = ($urandom_range(0, 3) == 0) ? t_vol'($urandom)
                                                       : t_vol'($urandom_range(0, 40));
        v.pan_position  = ($urandom_range(0, 3) == 0) ? PAN_W'($urandom)
                                                       : PAN_W'($urandom_range(0, 44));
        v.master_volume = t_scale_val'($urandom);
        v.se_type       = ($urandom_range(0, 2) == 0) ? SE_W'(0) : SE_W'($urandom);
        v.se_pan        = ($urandom_range(0, 3) == 0) ? SE_W'($urandom)
                                                       : SE_W'($urandom_range(0, 66));
        v.se_volume     = t_scale_val'($urandom);
        return v;
    endfunction

    task automatic queue_voice(t_item v);
        voice_feed.push_back(v);
        n_voices_queued++;
    endtask

    // Extremes of each field, both pan curves, clamping, decay floor
    task automatic queue_directed();
        queue_voice(mk_voice(5'd0,  8'd255, 8'd0,   10'd0,    16'hFFFF, 8'd0,   8'd0,   16'd0));
        queue_voice(mk_voice(5'd12, 8'd255, 8'd0,   10'd40,   16'hFFFF, 8'hFF,  8'hFF,  16'hFFFF));
        queue_voice(mk_voice(5'd7,  8'd255, 8'd0,   10'd1023, 16'hFFFF, 8'd0,   8'd0,   16'd0));
        queue_voice(mk_voice(5'd3,  8'd200, 8'd0,   10'd41,   16'h8000, 8'd5,   8'd9,   16'd7));
        queue_voice(mk_voice(5'd1,  8'd10,  8'd200, 10'd20,   16'hFFFF, 8'd0,   8'd0,   16'd0));
        queue_voice(mk_voice(5'd2,  8'd128, 8'd128, 10'd20,   16'hFFFF, 8'd0,   8'd0,   16'd0));
        queue_voice(mk_voice(5'd4,  8'd255, 8'd1,   10'd20,   16'd0,    8'd0,   8'd0,   16'd0));
        queue_voice(mk_voice(5'd13, 8'd255, 8'd0,   10'd20,   16'd0,    8'd0,   8'd64,  16'd0));
        queue_voice(mk_voice(5'd31, 8'd255, 8'd0,   10'd1023, 16'd0,    8'd0,   8'd255, 16'd0));
        queue_voice(mk_voice(5'd13, 8'd255, 8'd0,   10'd0,    16'd0,    8'd1,   8'd0,   16'hFFFF));
        queue_voice(mk_voice(5'd31, 8'd255, 8'd0,   10'd0,    16'd0,    8'hFF,  8'd64,  16'hFFFF));
        queue_voice(mk_voice(5'd20, 8'd255, 8'd0,   10'd0,    16'd0,    8'd128, 8'd65,  16'hFFFF));
        queue_voice(mk_voice(5'd25, 8'd255, 8'd0,   10'd0,    16'd0,    8'd2,   8'd255, 16'hFFFF));
        queue_voice(mk_voice(5'd18, 8'd255, 8'd0,   10'd0,    16'd0,    8'd9,   8'd32,  16'd0));
        queue_voice(mk_voice(5'd14, 8'd100, 8'd30,  10'd0,    16'd0,    8'd77,  8'd20,  16'h8000));
        queue_voice(mk_voice(5'd0,  8'd0,   8'd0,   10'd0,    16'd0,    8'd0,   8'd0,   16'd0));
        queue_voice(mk_voice(5'd31, 8'd255, 8'd255, 10'd1023, 16'hFFFF, 8'hFF,  8'hFF,  16'hFFFF));
        queue_voice(mk_voice(5'd31, 8'd255, 8'd0,   10'd1023, 16'hFFFF, 8'hFF,  8'hFF,  16'hFFFF));
        queue_voice(mk_voice(5'd0,  8'd255, 8'd0,   10'd1023, 16'hFFFF, 8'hFF,  8'hFF,  16'hFFFF));
        queue_voice(mk_voice(5'd13, 8'd1,   8'd0,   10'd40,   16'hFFFF, 8'd0,   8'd0,   16'hFFFF));
    endtask

    task automatic queue_random(int count);
        repeat (count) queue_voice(rand_voice());
    endtask

    // Hold until every queued beat went in and every result came back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (n_voices_in != n_voices_queued || mix_expected.size() != 0);
    endtask

    task automatic apb_xfer(input bit wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write one register with the pipeline empty, then read the mono switch back
    task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] value);
        logic [CFG_DW-1:0] rd;
        wait_drained();
        repeat (PIPE_SETTLE) @(posedge i_clk);
        apb_xfer(1'b1, {idx, 2'b00}, value, rd);
        if (idx == REG_MONO) mono_q = value[0];
        apb_xfer(1'b0, {REG_MONO, 2'b00}, '0, rd);
        if (rd[0] !== mono_q) begin
            $error("mono_output: expected %0d, got %0d", mono_q, rd[0]);
            n_errors++;
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Sender: offer queued beats, hold each until taken, idle in short bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_fire) begin
            if (send_gap > 0) begin
                send_gap    <= send_gap - 1;
                in_if.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                send_gap    <= $urandom_range(0, 3);
                in_if.valid <= 1'b0;
            end else if (voice_feed.size() != 0) begin
                {in_if.track, in_if.volume, in_if.decay_volume, in_if.pan_position,
                 in_if.master_volume, in_if.se_type, in_if.se_pan,
                 in_if.se_volume} <= voice_feed.pop_front();
                in_if.valid <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: one long stall to back the pipeline up, plus short random stalls while idling is on
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (!long_stall_done && n_voices_in >= LONG_STALL_AT) begin
            long_stall_done <= 1'b1;
            stall_left      <= LONG_STALL_CYCLES - 1;
            out_if.ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(0, 3);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Predict on each input beat, check each output beat against the oldest prediction
    always @(posedge i_clk) begin
        t_item taken;
        t_mix  want;
        in_fire <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                taken = {in_if.track, in_if.volume, in_if.decay_volume, in_if.pan_position,
                         in_if.master_volume, in_if.se_type, in_if.se_pan, in_if.se_volume};
                mix_expected.push_back(calc_voice_mix(taken, mono_q));
                n_voices_in++;
            end
            if (out_if.valid && out_if.ready) begin
                if (mix_expected.size() == 0) begin
                    $error("unexpected result beat for voice %0d", out_if.voice);
                    n_errors++;
                end else begin
                    want = mix_expected.pop_front();
                    if (out_if.voice !== want.voice) begin
                        $error("voice: expected %0d, got %0d", want.voice, out_if.voice);
                        n_errors++;
                    end
                    if (out_if.left_volume !== want.left_volume) begin
                        $error("left_volume: expected %0d, got %0d",
                               want.left_volume, out_if.left_volume);
                        n_errors++;
                    end
                    if (out_if.right_volume !== want.right_volume) begin
                        $error("right_volume: expected %0d, got %0d",
                               want.right_volume, out_if.right_volume);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without any beat or register access
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || psel || (in_if.valid && in_if.ready)
                    || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Sequence: reset, stereo phase, mono phase, spare register, stereo phase without idling
    initial begin
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_if.valid         = 1'b0;
        in_if.track         = '0;
        in_if.volume        = '0;
        in_if.decay_volume  = '0;
        in_if.pan_position  = '0;
        in_if.master_volume = '0;
        in_if.se_type       = '0;
        in_if.se_pan        = '0;
        in_if.se_volume     = '0;
        out_if.ready        = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Stereo from reset, with idling on both sides and the long receiver stall
        @(posedge i_clk);
        idle_on = 1'b1;
        queue_directed();
        queue_random(500);

        // Pause the sender until drained, then go mono
        cfg_write(REG_MONO, 32'd1);
        @(posedge i_clk);
        queue_directed();
        queue_random(380);

        // A write past the register list leaves mono in place
        cfg_write(REG_SPARE, 32'd0);
        cfg_write(REG_MONO, 32'd0);

        // Closing stretch at full rate
        @(posedge i_clk);
        idle_on = 1'b0;
        queue_random(300);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
